/* sv/bhm_pkg.sv */
// ----------------------------------------------------------------------------
// bhm_pkg: shared types and constants of the bucketed hash map
// Request and response transaction layouts, stored entry layout, request codes.
// ----------------------------------------------------------------------------
package bhm_pkg;

	localparam int KEY_W = 20;
	localparam int VAL_W = 20;
	localparam int RV_W  = 21;

	// Request codes; the fourth code is unused and leaves the store alone.
	localparam logic [1:0] REQ_PUT    = 2'd0;
	localparam logic [1:0] REQ_GET    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	// Response status codes.
	localparam logic ST_DONE = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [RV_W-1:0] read_value;
		logic                   status;
	} rsp_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	// Outcome of one bucket update, passed from the way logic to the top level.
	typedef struct packed {
		logic                   we;
		logic                   status;
		logic signed [RV_W-1:0] read_value;
	} upd_t;

endpackage

/* sv/bhm_ram.sv */
// ----------------------------------------------------------------------------
// bhm_ram: bucket memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module bhm_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 164,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/bhm_hash.sv */
// ----------------------------------------------------------------------------
// bhm_hash: bucket index unit
// Computes key modulo the bucket count by a reciprocal multiply, a
// back-multiply and one corrective subtract, over two register stages.
// ----------------------------------------------------------------------------
module bhm_hash
	import bhm_pkg::*;
#(
	parameter int BUCKETS = 1024,
	parameter int BIDX_W  = 10
) (
	input  logic              clk,
	input  logic              load,
	input  logic              advance,
	input  logic [KEY_W-1:0]  key,
	output logic [BIDX_W-1:0] bucket
);

	localparam int RECIP_W = KEY_W + 1;
	localparam int BK_W    = $clog2(BUCKETS + 1);
	localparam int RECIP   = (1 << KEY_W) / BUCKETS;
	localparam logic [RECIP_W-1:0] RECIP_C   = RECIP_W'(RECIP);
	localparam logic [BK_W-1:0]    BUCKETS_C = BK_W'(BUCKETS);
	localparam logic [KEY_W:0]     BUCKETS_R = (KEY_W+1)'(BUCKETS);

	logic [KEY_W-1:0]          key_s1;
	logic [RECIP_W-1:0]        quot_s1;
	logic [KEY_W-1:0]          key_s2;
	logic [KEY_W-1:0]          qb_s2;
	logic [KEY_W+RECIP_W-1:0]  prod;
	logic [RECIP_W+BK_W-1:0]   qb;
	logic [KEY_W:0]            rem;
	logic [KEY_W:0]            rem_fix;

	// Quotient estimate; it is the true quotient or one less.
	assign prod = key * RECIP_C;
	assign qb   = quot_s1 * BUCKETS_C;

	always_ff @(posedge clk) begin
		if (load) begin
			key_s1  <= key;
			quot_s1 <= prod[KEY_W+RECIP_W-1:KEY_W];
		end
		if (advance) begin
			key_s2 <= key_s1;
			qb_s2  <= qb[KEY_W-1:0];
		end
	end

	// Remainder lies below twice the bucket count: one compare and subtract.
	always_comb begin
		rem     = {1'b0, key_s2} - {1'b0, qb_s2};
		rem_fix = (rem >= BUCKETS_R) ? (rem - BUCKETS_R) : rem;
	end

	assign bucket = rem_fix[BIDX_W-1:0];

endmodule

/* sv/bhm_ways.sv */
// ----------------------------------------------------------------------------
// bhm_ways: way compare and update logic
// Compares all ways of one bucket with the key and builds the new bucket row
// and the response for a put, get or remove.
// ----------------------------------------------------------------------------
module bhm_ways
	import bhm_pkg::*;
#(
	parameter int WAYS = 4
) (
	input  req_t                row_req,
	input  entry_t [WAYS-1:0]   row,
	output entry_t [WAYS-1:0]   row_new,
	output upd_t                upd
);

	localparam int WIDX_W = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic              hit;
	logic              free;
	logic [WIDX_W-1:0] hit_idx;
	logic [WIDX_W-1:0] free_idx;

	// Lowest matching valid way and lowest free way.
	always_comb begin
		hit      = 1'b0;
		free     = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (!hit && row[w].valid && row[w].key == row_req.key) begin
				hit     = 1'b1;
				hit_idx = WIDX_W'(w);
			end
			if (!free && !row[w].valid) begin
				free     = 1'b1;
				free_idx = WIDX_W'(w);
			end
		end
	end

	// Row update and response by request code.
	always_comb begin
		row_new        = row;
		upd.we         = 1'b0;
		upd.status     = ST_DONE;
		upd.read_value = '1;
		case (row_req.req_type)
			REQ_PUT: begin
				if (hit) begin
					row_new[hit_idx].value = row_req.value;
					upd.we = 1'b1;
				end else if (free) begin
					row_new[free_idx].valid = 1'b1;
					row_new[free_idx].key   = row_req.key;
					row_new[free_idx].value = row_req.value;
					upd.we = 1'b1;
				end else begin
					upd.status = ST_FULL;
				end
			end
			REQ_GET: begin
				if (hit) begin
					upd.read_value = signed'({1'b0, row[hit_idx].value});
				end
			end
			REQ_REMOVE: begin
				if (hit) begin
					row_new[hit_idx].valid = 1'b0;
					upd.we = 1'b1;
				end
			end
			default: begin
				upd.we = 1'b0;
			end
		endcase
	end

endmodule

/* sv/bucketed_hash_map_core.sv */
// ----------------------------------------------------------------------------
// bucketed_hash_map_core: key-value hash map with a fixed number of ways
// Each request is a put, get or remove on the bucket selected by key modulo
// BUCKETS; every request returns exactly one response.
// ----------------------------------------------------------------------------
// Usage:
// - Request channel (req_valid, req_ready, req) carries put, get and remove
//   transactions. Response channel (rsp_valid, rsp_ready, rsp) returns the
//   value read (-1 when absent or not a get) and a full flag for puts.
// - One transaction is in work at a time. The acceptance edge loads the first
//   stage of the modulo unit. Its second stage, the synchronous bucket read and
//   the compare and write-back follow in that order, and the response is
//   registered with the write-back. req_ready returns in the cycle in which
//   the response becomes valid, so a new request is not accepted until the
//   previous one has passed through the modulo stages and the bucket read.
// - After reset the bucket memory is cleared one row per cycle; req_ready
//   stays low during this pass.
// - The response sits in an output register. A new request is accepted while
//   it waits; when the receiver stalls, the next request holds in its final
//   stage until the output register is free.
// ----------------------------------------------------------------------------
module bucketed_hash_map_core
	import bhm_pkg::*;
#(
	parameter int BUCKETS = 1024,
	parameter int WAYS    = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int BIDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int ROW_W  = WAYS * $bits(entry_t);
	localparam logic [BIDX_W-1:0] LAST_ROW = BIDX_W'(BUCKETS - 1);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_HASH   = 5'b00100,
		ST_READ   = 5'b01000,
		ST_UPDATE = 5'b10000
	} state_t;

	state_t            state_q;
	logic [BIDX_W-1:0] clr_cnt_q;
	req_t              req_q;
	logic [BIDX_W-1:0] bucket_q;
	rsp_t              rsp_q;
	logic              rsp_valid_q;

	logic              req_fire;
	logic              upd_fire;
	logic [BIDX_W-1:0] bucket;
	logic              mem_we;
	logic [BIDX_W-1:0] mem_waddr;
	logic [ROW_W-1:0]  mem_wdata;
	logic [ROW_W-1:0]  mem_rdata;
	entry_t [WAYS-1:0] row;
	entry_t [WAYS-1:0] row_new;
	upd_t              upd;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign upd_fire  = (state_q == ST_UPDATE) && (!rsp_valid_q || rsp_ready);

	// Modulo unit.
	bhm_hash #(
		.BUCKETS (BUCKETS),
		.BIDX_W  (BIDX_W)
	) u_hash (
		.clk     (clk),
		.load    (req_fire),
		.advance (state_q == ST_HASH),
		.key     (req.key),
		.bucket  (bucket)
	);

	// Memory write port: clearing pass or bucket write-back.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_we    = upd_fire && upd.we;
			mem_waddr = bucket_q;
			mem_wdata = row_new;
		end
	end

	bhm_ram #(
		.DEPTH (BUCKETS),
		.WIDTH (ROW_W),
		.AW    (BIDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (state_q == ST_READ),
		.raddr (bucket),
		.rdata (mem_rdata)
	);

	assign row = mem_rdata;

	// Way compare and row update.
	bhm_ways #(
		.WAYS (WAYS)
	) u_ways (
		.row_req (req_q),
		.row     (row),
		.row_new (row_new),
		.upd     (upd)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (upd_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (upd_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
		if (state_q == ST_READ) begin
			bucket_q <= bucket;
		end
		if (upd_fire) begin
			rsp_q.read_value <= upd.read_value;
			rsp_q.status     <= upd.status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Checks.
	a_accept_to_hash: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q == ST_HASH)
		else $error("accepted request did not enter the hash stage");

	a_bucket_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> bucket < BUCKETS)
		else $error("bucket index out of range");

	a_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_UPDATE))
		else $error("memory written outside clear or update");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_UPDATE)
		else $error("response raised without an update");

	a_full_only_put: assert property (@(posedge clk) disable iff (!arst_n)
		upd_fire && upd.status |-> req_q.req_type == REQ_PUT && upd.read_value == '1)
		else $error("full status on a request that is not a put");

endmodule
